>>> hw/rtl/qpt_pkg.sv
// Package for the quadrature position tracker: field widths, register
// indexes and the pin transition table.
// No dependencies.
package qpt_pkg;

    localparam int PIN_W   = 2;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [PIN_W-1:0]          t_pins;
    typedef logic signed [COUNT_W-1:0] t_count;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT    = 2'd0,
        CFG_UPPER_LIMIT    = 2'd1,
        CFG_LOWER_CLAMP_ON = 2'd2,
        CFG_UPPER_CLAMP_ON = 2'd3
    } t_cfg_idx;

    // Pin states
    localparam t_pins PINS_00 = 2'b00;
    localparam t_pins PINS_01 = 2'b01;
    localparam t_pins PINS_10 = 2'b10;
    localparam t_pins PINS_11 = 2'b11;

    // Count step for a move from last to pins; only moves out of 01 and 10 count
    function automatic logic signed [1:0] qpt_step(input t_pins last, input t_pins pins);
        logic signed [1:0] step;
        step = 2'sd0;
        if (last == PINS_01) begin
            if (pins == PINS_00) step = 2'sd1;
            else if (pins == PINS_11) step = -2'sd1;
        end else if (last == PINS_10) begin
            if (pins == PINS_00) step = -2'sd1;
            else if (pins == PINS_11) step = 2'sd1;
        end
        return step;
    endfunction

endpackage

>>> hw/rtl/qpt_pin_if.sv
// Input channel of the quadrature position tracker: one pin sample per item.
// Depends on qpt_pkg.
interface qpt_pin_if
    import qpt_pkg::*;
();
    logic  valid;
    logic  ready;
    t_pins pin_pair;

    modport source (output valid, output pin_pair, input ready);
    modport sink   (input valid, input pin_pair, output ready);
endinterface

>>> hw/rtl/qpt_move_if.sv
// Output channel of the quadrature position tracker: direction and distance.
// Depends on qpt_pkg.
interface qpt_move_if
    import qpt_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   moved_up;
    t_count distance;

    modport source (output valid, output moved_up, output distance, input ready);
    modport sink   (input valid, input moved_up, input distance, output ready);
endinterface

>>> hw/rtl/quadrature_position_tracker.sv
// Quadrature position tracker top level: count update, half-count report.
// Depends on qpt_pkg, qpt_pin_if and qpt_move_if.
//
//  channel   dir  handshake      payload
//  i_pin     in   valid/ready    pin_pair[1:0]
//  o_move    out  valid/ready    moved_up, distance[15:0] signed
//  i_cfg_*   in   write enable   i_cfg_idx[1:0], i_cfg_data[15:0]
//
// One sample is taken every cycle while the output register can be loaded;
// its result (if any) appears in the output register on the next cycle. The
// count update, clamp and half-count compare are one combinational pass from
// the state registers to the output register. Synchronous active-low reset
// clears state, limits and clamp enables. A stalled result blocks new samples
// only while the output register is full and not being taken.
module quadrature_position_tracker
    import qpt_pkg::*;
#(
    parameter int WRAP_LIMIT = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    qpt_pin_if.sink              i_pin,
    qpt_move_if.source           o_move
);

    localparam t_count WRAP_POS = t_count'(WRAP_LIMIT);
    localparam t_count WRAP_NEG = t_count'(-WRAP_LIMIT);
    localparam t_count COUNT_MAX = t_count'(32767);
    localparam t_count COUNT_MIN = t_count'(-32768);

    // Configuration registers
    t_count r_lower_limit;
    t_count r_upper_limit;
    logic   r_lower_clamp_on;
    logic   r_upper_clamp_on;

    // Tracking state
    logic   r_primed;
    t_pins  r_last_pins;
    t_count r_count;
    t_count r_reported_half;

    // Output register
    logic   r_out_valid;
    logic   r_out_moved_up;
    t_count r_out_distance;

    logic                       accept;
    logic                       load_out;
    logic signed [1:0]          step;
    logic signed [COUNT_W:0]    sum_ext;
    t_count                     sat_count;
    t_count                     clamp_lo;
    t_count                     clamp_hi;
    t_count                     n_count_upd;
    logic signed [COUNT_W:0]    half_ext;
    t_count                     half;
    t_count                     diff;
    logic                       has_result;
    logic                       wrap;

    // Handshake: take a sample whenever the output register can be loaded
    assign load_out    = !r_out_valid || o_move.ready;
    assign i_pin.ready = load_out;
    assign accept      = i_pin.valid && load_out;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit    <= '0;
            r_upper_limit    <= '0;
            r_lower_clamp_on <= 1'b0;
            r_upper_clamp_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOWER_LIMIT:    r_lower_limit    <= t_count'(i_cfg_data);
                CFG_UPPER_LIMIT:    r_upper_limit    <= t_count'(i_cfg_data);
                CFG_LOWER_CLAMP_ON: r_lower_clamp_on <= i_cfg_data[0];
                CFG_UPPER_CLAMP_ON: r_upper_clamp_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Count update: step, saturate, lower clamp then upper clamp
    always_comb begin
        step    = qpt_step(r_last_pins, i_pin.pin_pair);
        sum_ext = {r_count[COUNT_W-1], r_count} + (COUNT_W+1)'(step);
        if (sum_ext[COUNT_W] != sum_ext[COUNT_W-1]) begin
            sat_count = sum_ext[COUNT_W] ? COUNT_MIN : COUNT_MAX;
        end else begin
            sat_count = sum_ext[COUNT_W-1:0];
        end
        clamp_lo = (r_lower_clamp_on && (sat_count < r_lower_limit)) ? r_lower_limit
                                                                      : sat_count;
        clamp_hi = (r_upper_clamp_on && (clamp_lo > r_upper_limit)) ? r_upper_limit
                                                                     : clamp_lo;
        n_count_upd = (i_pin.pin_pair != r_last_pins) ? clamp_hi : r_count;
    end

    // Half count, truncated toward zero, and the compare with the last report
    always_comb begin
        half_ext   = ({n_count_upd[COUNT_W-1], n_count_upd}
                      + {{COUNT_W{1'b0}}, n_count_upd[COUNT_W-1]}) >>> 1;
        half       = half_ext[COUNT_W-1:0];
        diff       = half - r_reported_half;
        has_result = r_primed && (half != r_reported_half);
        wrap       = (n_count_upd > WRAP_POS) || (n_count_upd < WRAP_NEG);
    end

    // State update per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed        <= 1'b0;
            r_last_pins     <= '0;
            r_count         <= '0;
            r_reported_half <= '0;
        end else if (accept) begin
            r_primed    <= 1'b1;
            r_last_pins <= i_pin.pin_pair;
            if (r_primed) begin
                r_count <= (has_result && wrap) ? '0 : n_count_upd;
                if (has_result) begin
                    r_reported_half <= half;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= accept && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_result) begin
            r_out_moved_up <= !diff[COUNT_W-1];
            r_out_distance <= diff;
        end
    end

    assign o_move.valid    = r_out_valid;
    assign o_move.moved_up = r_out_moved_up;
    assign o_move.distance = r_out_distance;

    // Checks
    a_no_result_unprimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> !r_out_valid)
        else $error("result present before first sample");

    a_distance_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_distance != '0))
        else $error("zero distance reported");

    a_direction_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_moved_up == !r_out_distance[COUNT_W-1]))
        else $error("direction disagrees with distance sign");

    a_report_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_move.ready) |=> $stable(r_reported_half))
        else $error("reported half count moved while result stalled");

endmodule

>>> tb/quadrature_position_tracker_tb.sv
// Self-checking testbench for the quadrature position tracker: encoder walks
// under several clamp settings, checked against an in-bench position predictor.
// Depends on qpt_pkg, qpt_pin_if, qpt_move_if and quadrature_position_tracker.
module quadrature_position_tracker_tb;
    import qpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 5;
    localparam int WRAP        = 100;
    localparam int COUNT_MAX   = 32767;
    localparam int COUNT_MIN   = -32768;
    localparam int SETTLE      = 6;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_LEN    = 300;

    typedef struct packed {
        logic   moved_up;
        t_count distance;
    } t_move;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    qpt_pin_if  pin_ch ();
    qpt_move_if move_ch ();

    quadrature_position_tracker #(
        .WRAP_LIMIT(WRAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pin      (pin_ch),
        .o_move     (move_ch)
    );

    // Predicted tracker state and limits, reset values
    logic   seen_first  = 1'b0;
    t_pins  prev_pins   = PINS_00;
    t_count position    = '0;
    t_count last_half   = '0;
    t_count lim_lo      = '0;
    t_count lim_hi      = '0;
    logic   clamp_lo_on = 1'b0;
    logic   clamp_hi_on = 1'b0;

    t_move expected_moves[$];
    int    mismatches    = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_left     = 0;
    int    quiet_cycles  = 0;
    t_pins pin_now       = PINS_00;

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Count step for a pin transition: only moves out of 01 and 10 count
    function automatic int pin_step(input t_pins prev_p, input t_pins next_p);
        case (prev_p)
            PINS_01: return (next_p == PINS_00) ? 1 : (next_p == PINS_11) ? -1 : 0;
            PINS_10: return (next_p == PINS_11) ? 1 : (next_p == PINS_00) ? -1 : 0;
            default: return 0;
        endcase
    endfunction

    // Next Gray state; going up is 00 -> 10 -> 11 -> 01 -> 00
    function automatic t_pins gray_next(input t_pins p, input bit up);
        case (p)
            PINS_00: return up ? PINS_10 : PINS_01;
            PINS_10: return up ? PINS_11 : PINS_00;
            PINS_11: return up ? PINS_01 : PINS_10;
            default: return up ? PINS_00 : PINS_11;
        endcase
    endfunction

    // Advance the predicted position by one accepted sample
    task automatic advance_position(input t_pins p);
        int    next_pos;
        int    half;
        int    diff;
        t_move mv;
        if (!seen_first) begin
            seen_first = 1'b1;
            prev_pins  = p;
            return;
        end
        if (p != prev_pins) begin
            next_pos = int'(position) + pin_step(prev_pins, p);
            if (next_pos > COUNT_MAX) next_pos = COUNT_MAX;
            if (next_pos < COUNT_MIN) next_pos = COUNT_MIN;
            if (clamp_lo_on && next_pos < int'(lim_lo)) next_pos = lim_lo;
            if (clamp_hi_on && next_pos > int'(lim_hi)) next_pos = lim_hi;
            position  = t_count'(next_pos);
            prev_pins = p;
        end
        half = int'(position) / 2;
        if (half != int'(last_half)) begin
            diff        = half - int'(last_half);
            mv.moved_up = (diff > 0);
            mv.distance = t_count'(diff);
            expected_moves.push_back(mv);
            // zeroed count keeps the old report, so the next one shows the jump
            if (int'(position) > WRAP || int'(position) < -WRAP) position = '0;
            last_half = t_count'(half);
        end
    endtask

    // Offer one pin sample, with random gaps before it
    task automatic send_pin(input t_pins p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pin_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pin_ch.valid    <= 1'b1;
        pin_ch.pin_pair <= p;
        do @(posedge i_clk); while (pin_ch.ready !== 1'b1);
        advance_position(p);
        @(negedge i_clk);
    endtask

    // Wait for every predicted move to arrive, then let the pipeline drain
    task automatic settle_output();
        while (expected_moves.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write all four configuration registers while the tracker is idle
    task automatic load_limits(input t_count lo, input t_count hi,
                               input logic lo_on, input logic hi_on);
        t_cfg_idx         idx_list[4];
        logic [CFG_W-1:0] val_list[4];
        settle_output();
        idx_list = '{CFG_LOWER_LIMIT, CFG_UPPER_LIMIT, CFG_LOWER_CLAMP_ON, CFG_UPPER_CLAMP_ON};
        val_list = '{lo, hi, {15'($urandom), lo_on}, {15'($urandom), hi_on}};
        foreach (idx_list[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= val_list[k];
            @(posedge i_clk);
            case (idx_list[k])
                CFG_LOWER_LIMIT:    lim_lo      = t_count'(val_list[k]);
                CFG_UPPER_LIMIT:    lim_hi      = t_count'(val_list[k]);
                CFG_LOWER_CLAMP_ON: clamp_lo_on = val_list[k][0];
                CFG_UPPER_CLAMP_ON: clamp_hi_on = val_list[k][0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Encoder walks: long runs in one direction, some jitter, holds and skips
    task automatic send_walk(input int n_items);
        bit up;
        int run_left;
        int roll;
        up       = 1'b0;
        run_left = 0;
        repeat (n_items) begin
            if (run_left == 0) begin
                up       = 1'($urandom_range(0, 1));
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                       : $urandom_range(100, 600);
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 84) begin
                pin_now = gray_next(pin_now, up);
            end else if (roll < 90) begin
                pin_now = pin_now;
            end else if (roll < 95) begin
                pin_now = gray_next(pin_now, !up);
            end else begin
                pin_now = t_pins'($urandom_range(0, 3));
            end
            send_pin(pin_now);
        end
        pin_ch.valid <= 1'b0;
    endtask

    // First sample primes, then steps both ways, holds and skipped states
    task automatic test_directed_moves();
        t_pins seq[$];
        seq = '{PINS_00, PINS_00, PINS_10, PINS_11, PINS_01, PINS_00, PINS_10, PINS_11,
                PINS_01, PINS_00, PINS_01, PINS_11, PINS_10, PINS_00, PINS_01, PINS_11,
                PINS_10, PINS_00, PINS_11, PINS_00, PINS_01, PINS_10, PINS_01, PINS_00};
        foreach (seq[k]) send_pin(seq[k]);
        pin_ch.valid <= 1'b0;
        pin_now = seq[seq.size()-1];
    endtask

    task automatic test_free_count();
        load_limits(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_walk(175);
    endtask

    task automatic test_wide_clamps();
        load_limits(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
        send_walk(175);
    endtask

    // Lower limit at the top pins the count there, so up steps saturate
    task automatic test_top_saturation();
        load_limits(16'sd32767, 16'sd0, 1'b1, 1'b0);
        send_walk(175);
    endtask

    task automatic test_bottom_saturation();
        load_limits(16'sd0, -16'sd32768, 1'b0, 1'b1);
        send_walk(175);
    endtask

    // Lower limit above upper limit: the upper clamp has the last word
    task automatic test_crossed_limits();
        load_limits(16'sd20, -16'sd20, 1'b1, 1'b1);
        send_walk(175);
    endtask

    task automatic test_narrow_window();
        load_limits(-16'sd7, 16'sd9, 1'b1, 1'b1);
        send_walk(175);
    endtask

    task automatic test_random_limits();
        repeat (2) begin
            load_limits(t_count'($urandom_range(0, 16'hffff)),
                        t_count'($urandom_range(0, 16'hffff)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_walk(85);
        end
    endtask

    // Receiver holds off long enough for the output to fill and stall the input
    task automatic test_stalled_output();
        load_limits(-16'sd50, 16'sd120, 1'b1, 1'b1);
        hold_left = HOLD_LEN;
        send_walk(175);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            move_ch.ready <= 1'b0;
        end else begin
            move_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each delivered move with the oldest prediction
    always @(posedge i_clk) begin
        t_move want;
        if (i_rst_n && move_ch.valid === 1'b1 && move_ch.ready === 1'b1) begin
            if (expected_moves.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected move: up=%0b distance=%0d",
                             move_ch.moved_up, move_ch.distance);
            end else begin
                want = expected_moves.pop_front();
                if (move_ch.moved_up !== want.moved_up ||
                    move_ch.distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"move mismatch: expected up=%0b distance=%0d, ",
                                  "got up=%0b distance=%0d"},
                                 want.moved_up, want.distance,
                                 move_ch.moved_up, move_ch.distance);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1) ||
            (move_ch.valid === 1'b1 && move_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("quadrature_position_tracker_tb failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_LOWER_LIMIT;
        i_cfg_data       = '0;
        pin_ch.valid     = 1'b0;
        pin_ch.pin_pair  = PINS_00;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender rarely idle, receiver often stalled
        send_idle_pct = 8;
        recv_idle_pct = 59;
        test_directed_moves();
        test_free_count();
        test_wide_clamps();
        test_top_saturation();

        // roles swapped
        send_idle_pct = 59;
        recv_idle_pct = 8;
        test_bottom_saturation();
        test_crossed_limits();
        test_narrow_window();

        // full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_limits();
        test_stalled_output();

        settle_output();
        if (mismatches == 0) begin
            $display("quadrature_position_tracker_tb passed");
        end else begin
            $display("quadrature_position_tracker_tb failed");
        end
        $finish;
    end

endmodule
